@@ src/slds_pkg.sv @@
// slds_pkg: shared types, constants and helper functions for the serial-loaded
// digit scanner. Used by every module of the block; depends on nothing.
package slds_pkg;

  // field widths fixed by the interface
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned SCAN_IDX_W = 5;
  localparam int unsigned CODE_W     = 4;

  // beat kinds carried on in_tuser
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // digit codes and ascii bounds
  localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  // one buffered input beat
  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // ascii byte to digit code, blank for anything outside '0'..'9'
  function automatic logic [CODE_W-1:0] to_code(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] diff;
    diff = b - ASCII_ZERO;
    if (b inside {[ASCII_ZERO:ASCII_NINE]}) begin
      return diff[CODE_W-1:0];
    end
    return BLANK_CODE;
  endfunction

  // segment pattern a..g in bits 0..6, decimal point kept off
  function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] pat;
    case (code)
      4'd0:    pat = 8'h3f;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5b;
      4'd3:    pat = 8'h4f;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6d;
      4'd6:    pat = 8'h7d;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7f;
      4'd9:    pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

@@ src/slds_in_reg.sv @@
// slds_in_reg: input register for the scanner, holds one beat until the
// processing stage takes it. Depends on slds_pkg.
module slds_in_reg
  import slds_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  item_t in_item,
  input  logic  out_free,
  output logic  item_fire,
  output item_t item
);

  logic  v_r;
  item_t item_r;

  // a byte never waits; a tick waits for room in the result register
  assign item_fire = v_r && ((item_r.req_type == REQ_BYTE) || out_free);
  assign in_tready = !v_r || item_fire;
  assign item      = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      v_r <= 1'b1;
    end else if (item_fire) begin
      v_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ src/slds_digit_store.sv @@
// slds_digit_store: staging digits, shown digits and the frame byte count.
// Bytes fill the staging store; the frame-end byte copies it across.
// Depends on slds_pkg.
module slds_digit_store
  import slds_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_fire,
  input  logic [BYTE_W-1:0]             rx_byte,
  input  logic [$clog2(NUM_DIGITS)-1:0] rd_idx,
  output logic [CODE_W-1:0]             rd_code
);

  localparam int unsigned IDX_BITS = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W    = $clog2(NUM_DIGITS + 1);

  logic [CODE_W-1:0] staging_r [NUM_DIGITS];
  logic [CODE_W-1:0] shown_r   [NUM_DIGITS];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              frame_end;

  assign frame_end = (count_r >= CNT_W'(NUM_DIGITS));

  // byte count restarts after the frame-end byte
  always_comb begin
    count_nxt = count_r;
    if (byte_fire) begin
      count_nxt = frame_end ? '0 : count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // staging store, no reset
  always_ff @(posedge clk) begin
    if (byte_fire && !frame_end) begin
      staging_r[count_r[IDX_BITS-1:0]] <= to_code(rx_byte);
    end
  end

  // shown store, whole-frame copy on frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        shown_r[i] <= '0;
      end
    end else if (byte_fire && frame_end) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        shown_r[i] <= staging_r[i];
      end
    end
  end

  assign rd_code = shown_r[rd_idx];

endmodule

@@ src/slds_scan.sv @@
// slds_scan: scan position counter, segment decode and the result register.
// Reads the shown digit from slds_digit_store. Depends on slds_pkg.
module slds_scan
  import slds_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick_fire,
  output logic [$clog2(NUM_DIGITS)-1:0] rd_idx,
  input  logic [CODE_W-1:0]             rd_code,
  output logic                          out_free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [SEG_W-1:0]              out_segments,
  output logic [NUM_DIGITS-1:0]         out_select,
  output logic [SCAN_IDX_W-1:0]         out_index
);

  localparam int unsigned IDX_BITS = $clog2(NUM_DIGITS);

  logic [IDX_BITS-1:0]   pos_r;
  logic [IDX_BITS-1:0]   pos_nxt;
  logic [NUM_DIGITS-1:0] sel_nxt;
  logic                  out_v_r;
  logic [SEG_W-1:0]      seg_r;
  logic [NUM_DIGITS-1:0] sel_r;
  logic [SCAN_IDX_W-1:0] idx_r;

  // advance with wrap from the last digit to the first
  assign pos_nxt = (pos_r >= IDX_BITS'(NUM_DIGITS - 1)) ? '0 : pos_r + 1'b1;
  assign rd_idx  = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (tick_fire) begin
      pos_r <= pos_nxt;
    end
  end

  // active-low one-hot digit select
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      sel_nxt[i] = (pos_nxt != IDX_BITS'(i));
    end
  end

  // result register
  assign out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (tick_fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      seg_r <= seg_of(rd_code);
      sel_r <= sel_nxt;
      idx_r <= SCAN_IDX_W'(pos_nxt);
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_segments = seg_r;
  assign out_select   = sel_r;
  assign out_index    = idx_r;

endmodule

@@ src/serial_loaded_digit_scanner_unit.sv @@
// serial_loaded_digit_scanner_unit: top level of the serial-loaded multiplexed
// seven-segment scanner. Depends on slds_pkg, slds_in_reg, slds_digit_store
// and slds_scan.
// Result path: an accepted tick beat passes the input register, then the result
// register, to give its result beat; byte beats give no result.
// Throughput: one beat per cycle, limited only by out_tready on tick beats.
// Reset: synchronous active-low rst_n; shown digits read "0", count and scan
// position clear, staging digits hold until written.
module serial_loaded_digit_scanner_unit
  import slds_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // from bit 0: segments, digit_select, scan_index, zero fill to whole bytes
  output logic [((SEG_W + NUM_DIGITS + SCAN_IDX_W + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int unsigned IDX_BITS = $clog2(NUM_DIGITS);
  localparam int unsigned RES_W    = SEG_W + NUM_DIGITS + SCAN_IDX_W;
  localparam int unsigned OUT_W    = ((RES_W + 7) / 8) * 8;

  item_t                 in_item;
  item_t                 item;
  logic                  item_fire;
  logic                  out_free;
  logic                  byte_fire;
  logic                  tick_fire;
  logic [IDX_BITS-1:0]   rd_idx;
  logic [CODE_W-1:0]     rd_code;
  logic [SEG_W-1:0]      res_segments;
  logic [NUM_DIGITS-1:0] res_select;
  logic [SCAN_IDX_W-1:0] res_index;

  assign in_item.req_type = in_tuser;
  assign in_item.rx_byte  = in_tdata;

  slds_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .out_free  (out_free),
    .item_fire (item_fire),
    .item      (item)
  );

  // steer the beat by its kind
  assign byte_fire = item_fire && (item.req_type == REQ_BYTE);
  assign tick_fire = item_fire && (item.req_type == REQ_TICK);

  slds_digit_store #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (item.rx_byte),
    .rd_idx    (rd_idx),
    .rd_code   (rd_code)
  );

  slds_scan #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_fire    (tick_fire),
    .rd_idx       (rd_idx),
    .rd_code      (rd_code),
    .out_free     (out_free),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_segments (res_segments),
    .out_select   (res_select),
    .out_index    (res_index)
  );

  // pack result fields from the low end
  assign out_tdata = OUT_W'({res_index, res_select, res_segments});

endmodule

@@ verif/tb_serial_loaded_digit_scanner_unit.sv @@
// tb_serial_loaded_digit_scanner_unit: self-checking bench for the digit scanner, with a
// stream driver and monitor, a behavioural display model and several idle profiles.
// Depends on slds_pkg and serial_loaded_digit_scanner_unit.
module tb_serial_loaded_digit_scanner_unit
  import slds_pkg::*;
;

  localparam int unsigned NUM_DIGITS  = 18;
  localparam int unsigned OUT_W       = ((SEG_W + NUM_DIGITS + SCAN_IDX_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES = 8;

  // segment patterns for digits 0..9, digit 0 in the lowest byte
  localparam logic [10*SEG_W-1:0] SEG_ROM = {
    8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  typedef enum logic [2:0] {
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, HOLD_OFF
  } idle_mode_t;

  // one scan result beat as the display should see it
  typedef struct packed {
    logic [SEG_W-1:0]      seg;
    logic [NUM_DIGITS-1:0] sel;
    logic [SCAN_IDX_W-1:0] idx;
  } scan_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;

  // stimulus and checking state
  item_t        req_queue[$];
  scan_beat_t   due_scans[$];
  scan_beat_t   want;
  idle_mode_t   mode = IDLE_NONE;
  int unsigned  hold_left = 0;
  logic         hold_done = 1'b0;
  int unsigned  cycles = 0;
  int unsigned  errors = 0;
  int unsigned  beats_sent = 0;
  int unsigned  scans_checked = 0;
  int unsigned  frames_loaded = 0;

  // display model state
  logic [CODE_W-1:0]     staged [NUM_DIGITS];
  logic [CODE_W-1:0]     shown  [NUM_DIGITS];
  int unsigned           byte_cnt = 0;
  int unsigned           scan_pos = 0;

  serial_loaded_digit_scanner_unit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ascii byte to digit code, blank outside '0'..'9'
  function automatic logic [CODE_W-1:0] digit_code(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    d = b - ASCII_ZERO;
    if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
      return d[CODE_W-1:0];
    end
    return BLANK_CODE;
  endfunction

  // update the display model with one accepted beat, queue the scan it causes
  function automatic void advance_display(input item_t it);
    scan_beat_t s;
    if (it.req_type == REQ_BYTE) begin
      if (byte_cnt < NUM_DIGITS) begin
        staged[byte_cnt] = digit_code(it.rx_byte);
        byte_cnt++;
      end else begin
        // frame end: byte dropped, staged digits go live together
        shown = staged;
        byte_cnt = 0;
        frames_loaded++;
      end
    end else begin
      scan_pos = (scan_pos >= NUM_DIGITS - 1) ? 0 : scan_pos + 1;
      s.seg = (shown[scan_pos] < 10) ? SEG_ROM[shown[scan_pos]*SEG_W +: SEG_W] : '0;
      s.sel = '1;
      s.sel[scan_pos] = 1'b0;
      s.idx = scan_pos[SCAN_IDX_W-1:0];
      due_scans.push_back(s);
    end
  endfunction

  function automatic logic send_gap();
    case (mode)
      IDLE_SEND: return $urandom_range(0, 99) < 59;
      IDLE_BOTH: return $urandom_range(0, 99) < 23;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (mode)
      IDLE_RECV: return $urandom_range(0, 99) < 59;
      IDLE_BOTH: return $urandom_range(0, 99) < 23;
      HOLD_OFF:  return (hold_left != 0) || ($urandom_range(0, 99) < 30);
      default:   return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  task automatic push_req(input logic kind, input logic [BYTE_W-1:0] b);
    item_t it;
    it.req_type = kind;
    it.rx_byte  = b;
    req_queue.push_back(it);
  endtask

  // random mix of ticks and bytes; most bytes are digits so frames show numbers
  task automatic push_random(input int unsigned n, input int unsigned tick_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        push_req(REQ_TICK, BYTE_W'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 99) < 80) begin
        push_req(REQ_BYTE, ASCII_ZERO + BYTE_W'($urandom_range(0, 9)));
      end else begin
        push_req(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_sent();
    while (req_queue.size() != 0 || in_tvalid) @(negedge clk);
  endtask

  // input driver: presents queued beats, holds each until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_display('{req_type: in_tuser, rx_byte: in_tdata});
        beats_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() != 0 && !send_gap()) begin
          in_tvalid <= 1'b1;
          in_tuser  <= req_queue[0].req_type;
          in_tdata  <= req_queue[0].rx_byte;
          void'(req_queue.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once when the pressure phase starts
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (mode == HOLD_OFF && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: field compare against the oldest expected scan
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_scans.size() == 0) begin
          report_mismatch("unexpected result beat", 0, out_tdata);
        end else begin
          want = due_scans.pop_front();
          scans_checked++;
          if (out_tdata[0 +: SEG_W] !== want.seg)
            report_mismatch("segments", want.seg, out_tdata[0 +: SEG_W]);
          if (out_tdata[SEG_W +: NUM_DIGITS] !== want.sel)
            report_mismatch("digit_select", want.sel, out_tdata[SEG_W +: NUM_DIGITS]);
          if (out_tdata[SEG_W+NUM_DIGITS +: SCAN_IDX_W] !== want.idx)
            report_mismatch("scan_index", want.idx,
                            out_tdata[SEG_W+NUM_DIGITS +: SCAN_IDX_W]);
        end
      end
      out_tready <= !recv_stall();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d scans outstanding", cycles, due_scans.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    for (int i = 0; i < NUM_DIGITS; i++) shown[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset display, ignored byte on a tick, one frame of edge bytes
    push_req(REQ_TICK, 8'h00);
    push_req(REQ_TICK, 8'hff);
    for (int d = 0; d < 10; d++) push_req(REQ_BYTE, ASCII_ZERO + BYTE_W'(d));
    push_req(REQ_BYTE, 8'h00);
    push_req(REQ_BYTE, 8'hff);
    push_req(REQ_BYTE, ASCII_ZERO - 8'd1);
    push_req(REQ_BYTE, ASCII_NINE + 8'd1);
    push_req(REQ_BYTE, 8'h80);
    push_req(REQ_BYTE, 8'h7f);
    push_req(REQ_TICK, 8'h5a);
    push_req(REQ_BYTE, 8'h39);
    push_req(REQ_BYTE, 8'h30);
    // frame end byte, a digit that must not be shown
    push_req(REQ_BYTE, 8'h35);
    push_req(REQ_TICK, 8'ha5);
    wait_sent();

    // random phases with different idle profiles
    push_random(500, 45);
    wait_sent();
    mode = IDLE_SEND;
    push_random(400, 45);
    wait_sent();
    mode = IDLE_RECV;
    push_random(400, 45);
    wait_sent();
    mode = IDLE_BOTH;
    push_random(400, 45);
    wait_sent();
    // tick-heavy stream against a held-off receiver, so the input stalls
    mode = HOLD_OFF;
    push_random(300, 70);
    wait_sent();

    while (due_scans.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d request beats, %0d scan beats checked, %0d frames loaded",
             beats_sent, scans_checked, frames_loaded);
    $display("idle profiles: none, sender, receiver, both, and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
